[rtl/lmd_pkg.sv]
package lmd_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = IdxW + 1;
  localparam int AddrW = IdxW + 1;
  localparam int SineEntries = 256;
  localparam int SineW = $clog2(SineEntries);

  localparam logic [1:0] CMD_POSE = 2'd0;
  localparam logic [1:0] CMD_LMK  = 2'd1;

  localparam logic [2:0] ST_POSE  = 3'd0;
  localparam logic [2:0] ST_ADDED = 3'd1;
  localparam logic [2:0] ST_DUP   = 3'd2;
  localparam logic [2:0] ST_NOPOSE = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;

  localparam logic [22:0] DupReset = 23'd196608;

  // quarter-wave polynomial sine, signed q3.15 (1.0 = 32768)
  function automatic logic signed [17:0] quarter_sine(input logic [14:0] r);
    logic [63:0] z, z2, t1, t2;
    z = {49'd0, r} << 1;
    z2 = (z * z) >> 15;
    t1 = 64'd21024 - ((z2 * 64'd2320) >> 15);
    t2 = 64'd51472 - ((z2 * t1) >> 15);
    return 18'($signed({1'b0, 17'((z * t2) >> 15)}));
  endfunction

  function automatic logic signed [17:0] sine_entry(input logic [SineW-1:0] k);
    logic [15:0] a;
    logic [14:0] r;
    logic signed [17:0] s;
    a = 16'((32'(k) << 16) / SineEntries);
    r = {1'b0, a[13:0]};
    s = a[14] ? quarter_sine(15'(15'd16384 - r)) : quarter_sine(r);
    return a[15] ? -s : s;
  endfunction

  typedef logic [SineEntries-1:0][17:0] sine_tab_t;

  function automatic sine_tab_t sine_table();
    sine_tab_t t;
    for (int k = 0; k < SineEntries; k++) t[k] = sine_entry(SineW'(k));
    return t;
  endfunction

  // sine per heading step, filled at elaboration
  localparam sine_tab_t SineTab = sine_table();

endpackage

[rtl/lmd_ram.sv]
module lmd_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/landmark_map_dedup_insert.sv]
// landmark map with distance-gated insert
// in_tuser/in_tdata beat: a pose, a landmark observation or a read of one stored entry.
// out_tuser/out_tdata beat: exactly one result per input beat, in order.
// a pose, or a landmark before any pose, goes from decode straight to the output
// state; a read passes S_READ first; a landmark passes the multiply states, the
// sum state and a scan of the n entries held in its color table (at most 64), cut
// short when a duplicate ends the scan: each stored entry takes a memory read state
// (S_SCAN) and a compare state (S_WAIT); the transform uses one 32x18 multiplier.
// in_tready is high only while the core is idle, so it rises again in the cycle
// after the previous result is loaded into the output register.
// while the receiver stalls, the core finishes one more beat and holds it
// until the output register frees; in_tready stays low meanwhile.
// reset (rst_n low, synchronous) clears pose and counts and sets gate radius to 3.0 m;
// stored entries are only read below the fill count, so no clearing pass.
// cfg_wr_en writes the gate radius; write it only while idle.
module landmark_map_dedup_insert (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command
  input  logic [1:0]   in_tuser,
  // pos_x, pos_y, pos_z, heading, color, entry_index, zero pad
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status
  output logic [2:0]   out_tuser,
  // out_x, out_y, out_z, table_count, zero pad
  output logic [103:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic [22:0]  cfg_wr_data
);
  localparam int IdxW = lmd_pkg::IdxW;
  localparam int CntW = lmd_pkg::CntW;
  localparam int AddrW = lmd_pkg::AddrW;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_SCAN, S_CHK, S_WAIT,
    S_READ, S_OUT
  } state_t;

  state_t state_r;
  logic [1:0] cmd_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic color_r;
  logic [IdxW-1:0] idx_r;
  logic signed [31:0] rx_r, ry_r;
  logic [15:0] rh_r;
  logic pose_valid_r;
  logic [CntW-1:0] cnt_r [2];
  logic [22:0] dup_r;
  logic signed [17:0] sin_r, cos_r;
  logic signed [49:0] prod_r;
  logic signed [50:0] accx_r, accy_r;
  logic signed [31:0] gx_r, gy_r;
  logic [CntW-1:0] scan_r;
  logic dup_hit_r;
  logic [2:0] st_r;
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic [CntW-1:0] tc_r;
  logic ovalid_r;
  logic [2:0] res_user_r;
  logic [102:0] res_data_r;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [63:0] xy_rd;
  logic [31:0] h_rd;
  logic [CntW-1:0] cur_cnt;
  logic out_free;

  assign cur_cnt = cnt_r[color_r];
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tuser = res_user_r;
  assign out_tdata = {1'b0, res_data_r};
  assign out_free = !ovalid_r || out_tready;

  assign we = (state_r == S_CHK) && !dup_hit_r && !cur_cnt[CntW-1];
  assign waddr = {color_r, cur_cnt[IdxW-1:0]};
  assign raddr = (state_r == S_DEC) ? {color_r, idx_r} : {color_r, scan_r[IdxW-1:0]};

  lmd_ram #(.Width(64), .Depth(2 * lmd_pkg::TableDepth)) u_xy (
    .clk(clk), .we(we), .waddr(waddr), .wdata({gy_r, gx_r}), .raddr(raddr), .rdata(xy_rd)
  );
  lmd_ram #(.Width(32), .Depth(2 * lmd_pkg::TableDepth)) u_h (
    .clk(clk), .we(we), .waddr(waddr), .wdata(pz_r), .raddr(raddr), .rdata(h_rd)
  );

  // multiplier operand select, one product per cycle
  logic signed [31:0] m_a;
  logic signed [17:0] m_b;
  logic signed [49:0] prod_nxt;
  always_comb begin
    case (state_r)
      S_MUL0:  begin m_a = px_r; m_b = cos_r; end
      S_MUL1:  begin m_a = py_r; m_b = sin_r; end
      S_MUL2:  begin m_a = px_r; m_b = sin_r; end
      default: begin m_a = py_r; m_b = cos_r; end
    endcase
  end
  assign prod_nxt = 50'(m_a) * 50'(m_b);

  // distance gate against the entry read last cycle
  logic signed [32:0] dx, dy;
  logic [32:0] adx, ady;
  logic [22:0] adx_s, ady_s;
  logic [46:0] dd;
  logic near;
  always_comb begin
    dx = 33'(gx_r) - 33'($signed(xy_rd[31:0]));
    dy = 33'(gy_r) - 33'($signed(xy_rd[63:32]));
    adx = dx[32] ? 33'(-dx) : 33'(dx);
    ady = dy[32] ? 33'(-dy) : 33'(dy);
    adx_s = adx[22:0];
    ady_s = ady[22:0];
    dd = 47'(dup_r) * 47'(dup_r);
    near = (adx < 33'(dup_r)) && (ady < 33'(dup_r)) &&
           ((47'(adx_s) * 47'(adx_s) + 47'(ady_s) * 47'(ady_s)) < dd);
  end

  function automatic logic signed [31:0] sat(input logic signed [51:0] v);
    if (v > 52'sd2147483647) return 32'sh7fffffff;
    if (v < -52'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic [lmd_pkg::SineW-1:0] ks, kc;
  logic [15:0] hc;
  assign hc = rh_r + 16'd16384;
  assign ks = rh_r[15 -: lmd_pkg::SineW];
  assign kc = hc[15 -: lmd_pkg::SineW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
      pose_valid_r <= 1'b0;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      rx_r <= '0;
      ry_r <= '0;
      rh_r <= '0;
      dup_r <= lmd_pkg::DupReset;
    end else begin
      if (cfg_wr_en) dup_r <= cfg_wr_data;
      if (state_r == S_OUT && out_free) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          cmd_r <= in_tuser;
          px_r <= in_tdata[31:0];
          py_r <= in_tdata[63:32];
          pz_r <= in_tdata[95:64];
          color_r <= in_tdata[112];
          idx_r <= in_tdata[118:113];
          if (in_tuser == lmd_pkg::CMD_POSE) begin
            rx_r <= in_tdata[31:0];
            ry_r <= in_tdata[63:32];
            rh_r <= in_tdata[111:96];
            pose_valid_r <= 1'b1;
          end
          state_r <= S_DEC;
        end
        S_DEC: begin
          sin_r <= $signed(lmd_pkg::SineTab[ks]);
          cos_r <= $signed(lmd_pkg::SineTab[kc]);
          tc_r <= cur_cnt;
          if (cmd_r == lmd_pkg::CMD_POSE) begin
            st_r <= lmd_pkg::ST_POSE;
            ox_r <= px_r; oy_r <= py_r; oz_r <= '0;
            state_r <= S_OUT;
          end else begin
            ox_r <= '0; oy_r <= '0; oz_r <= '0;
            if (cmd_r == lmd_pkg::CMD_LMK) begin
              if (!pose_valid_r) begin
                st_r <= lmd_pkg::ST_NOPOSE;
                state_r <= S_OUT;
              end else state_r <= S_MUL0;
            end else begin
              st_r <= lmd_pkg::ST_READ;
              state_r <= S_READ;
            end
          end
        end
        S_MUL0: begin prod_r <= prod_nxt; state_r <= S_MUL1; end
        S_MUL1: begin
          accx_r <= 51'(prod_r) + 51'sd16384;
          prod_r <= prod_nxt; state_r <= S_MUL2;
        end
        S_MUL2: begin
          accx_r <= accx_r - 51'(prod_r);
          prod_r <= prod_nxt; state_r <= S_MUL3;
        end
        S_MUL3: begin
          accy_r <= 51'(prod_r) + 51'sd16384;
          prod_r <= prod_nxt; state_r <= S_SUM;
        end
        S_SUM: begin
          gx_r <= sat(52'(rx_r) + 52'(accx_r >>> 15));
          gy_r <= sat(52'(ry_r) + 52'((accy_r + 51'(prod_r)) >>> 15));
          scan_r <= '0;
          dup_hit_r <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          // read address issued; next cycle compares
          if (scan_r >= cur_cnt || dup_hit_r) state_r <= S_CHK;
          else begin
            scan_r <= scan_r + 1'b1;
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (near) dup_hit_r <= 1'b1;
          state_r <= S_SCAN;
        end
        S_CHK: begin
          ox_r <= gx_r; oy_r <= gy_r; oz_r <= pz_r;
          if (dup_hit_r) st_r <= lmd_pkg::ST_DUP;
          else if (cur_cnt[CntW-1]) st_r <= lmd_pkg::ST_FULL;
          else begin
            st_r <= lmd_pkg::ST_ADDED;
            cnt_r[color_r] <= cur_cnt + 1'b1;
          end
          tc_r <= we ? CntW'(cur_cnt + 1'b1) : cur_cnt;
          state_r <= S_OUT;
        end
        S_READ: begin
          if (CntW'(idx_r) < cur_cnt) begin
            ox_r <= xy_rd[31:0]; oy_r <= xy_rd[63:32]; oz_r <= h_rd;
          end
          state_r <= S_OUT;
        end
        S_OUT: if (out_free) begin
          res_user_r <= st_r;
          res_data_r <= {tc_r, oz_r, oy_r, ox_r};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/lmd_checker.sv]
module lmd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [2:0]   out_tuser,
  input logic [103:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result dropped or changed while stalled");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= 3'd5)
    else $error("bad status code");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[102:96] <= 7'd64)
    else $error("count past table depth");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken before result");
endmodule

bind landmark_map_dedup_insert lmd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
  .out_tdata(out_tdata)
);

[dv/landmark_map_dedup_insert_tb.sv]
`timescale 1ns / 100ps

module landmark_map_dedup_insert_tb;

  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;   // decodes as a read
  localparam int         CYCLE_LIMIT = 1000000;
  localparam logic [22:0] GATE_MAX = 23'h7FFFFF;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [15:0]        hdg;
    logic               col;
    logic [5:0]         idx;
  } obs_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
    logic [6:0]         cnt;
  } map_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser = '0;
  logic [119:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [2:0]   out_tuser;
  logic [103:0] out_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [22:0]  cfg_wr_data = '0;

  landmark_map_dedup_insert DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // predictor state
  int signed   lm_x [2*lmd_pkg::TableDepth];
  int signed   lm_y [2*lmd_pkg::TableDepth];
  int signed   lm_z [2*lmd_pkg::TableDepth];
  int          lm_cnt [2];
  int signed   pose_x, pose_y;
  logic [15:0] pose_hdg;
  bit          pose_ok;
  logic [22:0] gate_radius;

  map_res_t pending_results [$];
  int       errors = 0;
  int       cycles = 0;
  bit       idle_on = 1'b1;
  bit       press_go = 1'b0;
  logic     rx_hold = 1'b0;

  initial forever #1 clk = ~clk;

  function automatic longint sin_lookup(logic [15:0] ang);
    longint k, a, r, z, z2, t1, t2, s;
    k = (longint'(ang) * lmd_pkg::SineEntries) >> 16;
    a = ((k << 16) / lmd_pkg::SineEntries) & 64'hFFFF;
    r = a & 64'h3FFF;
    z = (a & 64'h4000) ? 2 * (16384 - r) : 2 * r;
    z2 = (z * z) >> 15;
    t1 = 21024 - ((z2 * 2320) >> 15);
    t2 = 51472 - ((z2 * t1) >> 15);
    s = (z * t2) >> 15;
    return (a & 64'h8000) ? -s : s;
  endfunction

  function automatic int signed sat32(longint v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic bit near_entry(int signed ax, int signed ay, int signed bx,
                                    int signed by);
    longint dx, dy, d;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    d = longint'(gate_radius);
    if (dx >= d || dy >= d) return 1'b0;
    return (dx * dx + dy * dy) < d * d;
  endfunction

  function automatic map_res_t map_update(obs_t o);
    map_res_t r;
    longint s, c, rx, ry;
    int base, n;
    bit dup;
    r = '0;
    base = o.col * lmd_pkg::TableDepth;
    n = lm_cnt[o.col];
    if (o.cmd == lmd_pkg::CMD_POSE) begin
      pose_x = o.px;
      pose_y = o.py;
      pose_hdg = o.hdg;
      pose_ok = 1'b1;
      r.status = lmd_pkg::ST_POSE;
      r.gx = o.px;
      r.gy = o.py;
    end else if (o.cmd == lmd_pkg::CMD_LMK) begin
      if (!pose_ok) begin
        r.status = lmd_pkg::ST_NOPOSE;
      end else begin
        s = sin_lookup(pose_hdg);
        c = sin_lookup(pose_hdg + 16'd16384);
        rx = (longint'(o.px) * c - longint'(o.py) * s + 16384) >>> 15;
        ry = (longint'(o.px) * s + longint'(o.py) * c + 16384) >>> 15;
        r.gx = sat32(longint'(pose_x) + rx);
        r.gy = sat32(longint'(pose_y) + ry);
        r.gz = o.pz;
        dup = 1'b0;
        for (int i = 0; i < n; i++)
          if (!dup && near_entry(r.gx, r.gy, lm_x[base+i], lm_y[base+i])) dup = 1'b1;
        if (dup) begin
          r.status = lmd_pkg::ST_DUP;
        end else if (n >= lmd_pkg::TableDepth) begin
          r.status = lmd_pkg::ST_FULL;
        end else begin
          lm_x[base+n] = r.gx;
          lm_y[base+n] = r.gy;
          lm_z[base+n] = r.gz;
          lm_cnt[o.col] = n + 1;
          r.status = lmd_pkg::ST_ADDED;
        end
      end
    end else begin
      r.status = lmd_pkg::ST_READ;
      if (o.idx < n) begin
        r.gx = lm_x[base+o.idx];
        r.gy = lm_y[base+o.idx];
        r.gz = lm_z[base+o.idx];
      end
    end
    r.cnt = 7'(lm_cnt[o.col]);
    return r;
  endfunction

  task automatic send_obs(obs_t o);
    int gap;
    gap = (idle_on && $urandom_range(99) < 15) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= o.cmd;
    in_tdata <= {1'b0, o.idx, o.col, o.hdg, o.pz, o.py, o.px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.insert(pending_results.size(), map_update(o));
  endtask

  task automatic set_gate(logic [22:0] v);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gate_radius = v;
  endtask

  function automatic obs_t mk(logic [1:0] cmd, int signed x, int signed y, int signed z,
                              logic [15:0] h, logic col, logic [5:0] idx);
    obs_t o;
    o.cmd = cmd; o.px = x; o.py = y; o.pz = z; o.hdg = h; o.col = col; o.idx = idx;
    return o;
  endfunction

  function automatic int signed rand_coord();
    case ($urandom_range(3))
      0: return int'($urandom);
      1: return 32'sh7FFFFFFF - int'($urandom_range(0, 65536 * 4));
      default: return int'($urandom_range(0, 100 * 65536)) - 50 * 65536;
    endcase
  endfunction

  function automatic obs_t rand_obs();
    obs_t o;
    int pick;
    pick = $urandom_range(99);
    o.cmd = (pick < 10) ? lmd_pkg::CMD_POSE : (pick < 65) ? lmd_pkg::CMD_LMK :
            (pick < 95) ? CMD_READ : CMD_SPARE;
    o.px = rand_coord();
    o.py = rand_coord();
    o.pz = int'($urandom);
    o.hdg = 16'($urandom);
    o.col = 1'($urandom);
    o.idx = 6'($urandom);
    return o;
  endfunction

  task automatic test_directed();
    send_obs(mk(lmd_pkg::CMD_LMK, 32'sd65536, 0, 32'sd1000, 16'hFFFF, 1'b0, 0)); // no pose yet
    send_obs(mk(lmd_pkg::CMD_POSE, 0, 0, 0, 16'h0000, 1'b0, 0));
    send_obs(mk(lmd_pkg::CMD_LMK, 32'sd65536, 32'sd131072, 32'sd5, 0, 1'b0, 0));
    send_obs(mk(lmd_pkg::CMD_LMK, 32'sd70000, 32'sd131072, -32'sd5, 0, 1'b0, 0)); // duplicate
    send_obs(mk(CMD_READ, 0, 0, 0, 0, 1'b0, 6'd0));
    send_obs(mk(CMD_READ, 0, 0, 0, 0, 1'b0, 6'd63));                     // beyond count
    send_obs(mk(CMD_SPARE, 0, 0, 0, 0, 1'b0, 6'd0));
    send_obs(mk(lmd_pkg::CMD_POSE, 32'sh7FFFFFFF, 32'sh80000000, 0, 16'h4000, 1'b1, 0));
    send_obs(mk(lmd_pkg::CMD_LMK, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 1'b1, 0));
    send_obs(mk(lmd_pkg::CMD_LMK, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 1'b1, 0));
    send_obs(mk(lmd_pkg::CMD_POSE, 32'sh80000000, 32'sh7FFFFFFF, 0, 16'h8000, 1'b0, 0));
    send_obs(mk(lmd_pkg::CMD_LMK, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 1'b0, 0));
    send_obs(mk(lmd_pkg::CMD_POSE, 32'sd100, -32'sd100, 0, 16'hC123, 1'b1, 0));
    send_obs(mk(lmd_pkg::CMD_LMK, -32'sd300000, 32'sd400000, 32'sd7, 16'hFFFF, 1'b1, 0));
    send_obs(mk(CMD_READ, 0, 0, 0, 0, 1'b1, 6'd2));
    send_obs(mk(CMD_READ, 0, 0, 0, 0, 1'b1, 6'd1));
  endtask

  task automatic test_zero_gate();
    set_gate(23'd0);
    send_obs(mk(lmd_pkg::CMD_POSE, 0, 0, 0, 0, 1'b0, 0));
    repeat (3) send_obs(mk(lmd_pkg::CMD_LMK, 32'sd65536, 32'sd131072, 0, 0, 1'b0, 0));
    send_obs(mk(CMD_READ, 0, 0, 0, 0, 1'b0, 6'd3));
  endtask

  task automatic test_random(int count, logic [22:0] gate);
    set_gate(gate);
    repeat (count) send_obs(rand_obs());
  endtask

  task automatic test_no_idle(int count);
    idle_on = 1'b0;
    repeat (count) send_obs(rand_obs());
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    press_go = 1'b1;
    repeat (30) send_obs(rand_obs());
  endtask

  // long receiver hold-off while the sender keeps offering beats
  initial begin
    wait (press_go);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    map_res_t got, want;
    out_tready <= rx_hold ? 1'b0 : (idle_on ? ($urandom_range(99) >= 15) : 1'b1);
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.gx = out_tdata[31:0];
      got.gy = out_tdata[63:32];
      got.gz = out_tdata[95:64];
      got.cnt = out_tdata[102:96];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.gx !== want.gx) begin
          errors++;
          $display("%0t: x expected %0d actual %0d", $time, want.gx, got.gx);
        end
        if (got.gy !== want.gy) begin
          errors++;
          $display("%0t: y expected %0d actual %0d", $time, want.gy, got.gy);
        end
        if (got.gz !== want.gz) begin
          errors++;
          $display("%0t: z expected %0d actual %0d", $time, want.gz, got.gz);
        end
        if (got.cnt !== want.cnt) begin
          errors++;
          $display("%0t: count expected %0d actual %0d", $time, want.cnt, got.cnt);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("landmark_map_dedup_insert: mismatch");
      $finish;
    end
  end

  initial begin
    lm_cnt[0] = 0;
    lm_cnt[1] = 0;
    pose_x = 0;
    pose_y = 0;
    pose_hdg = '0;
    pose_ok = 1'b0;
    gate_radius = lmd_pkg::DupReset;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_zero_gate();
    test_random(300, lmd_pkg::DupReset);
    test_no_idle(150);
    test_backpressure();
    test_random(250, GATE_MAX);
    test_random(250, 23'($urandom));
    test_random(250, 23'd1);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("landmark_map_dedup_insert: match");
    else
      $display("landmark_map_dedup_insert: mismatch");
    $finish;
  end

endmodule

[filelist.f]
rtl/lmd_pkg.sv
rtl/lmd_ram.sv
rtl/landmark_map_dedup_insert.sv
rtl/lmd_checker.sv
dv/landmark_map_dedup_insert_tb.sv
